/* src/greedy_k_server_policy_core_macros.svh */
// ----------------------------------------------------------------------------
// greedy k-server core assertion macros
// shared property shorthands for the core's checks
// ----------------------------------------------------------------------------
`ifndef GREEDY_K_SERVER_POLICY_CORE_MACROS_SVH
`define GREEDY_K_SERVER_POLICY_CORE_MACROS_SVH

// same-cycle implication
`define GKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/gks_pkg.sv */
// ----------------------------------------------------------------------------
// gks_pkg
// sizes, beat types and request codes for the greedy k-server core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gks_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int MAX_SERVERS = 8;
  localparam int DIST_BITS   = 16;
  localparam int PT_W        = $clog2(MAX_POINTS);
  localparam int SRV_W       = $clog2(MAX_SERVERS);
  localparam int ADDR_W      = 2 * PT_W;
  localparam int COST_W      = 32;
  localparam int NSRV_W      = 4;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_SERVE   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [PT_W-1:0]      point_a;
    logic [PT_W-1:0]      point_b;
    logic [DIST_BITS-1:0] distance;
  } gks_in_t;

  typedef struct packed {
    logic [SRV_W-1:0]     server_index;
    logic                 moved;
    logic [DIST_BITS-1:0] step_cost;
    logic [COST_W-1:0]    total_cost;
  } gks_out_t;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic [SRV_W-1:0] idx;
  } gks_cand_t;

endpackage

/* src/gks_dist_ram.sv */
// ----------------------------------------------------------------------------
// gks_dist_ram
// distance table, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gks_dist_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [gks_pkg::ADDR_W-1:0]    waddr,
  input  logic [gks_pkg::DIST_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [gks_pkg::ADDR_W-1:0]    raddr,
  output logic [gks_pkg::DIST_BITS-1:0] rdata
);
  import gks_pkg::*;

  logic [DIST_BITS-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/gks_min_unit.sv */
// ----------------------------------------------------------------------------
// gks_min_unit
// shared compare unit, keeps the nearest server seen during a scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gks_min_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gks_pkg::gks_cand_t            issue,
  input  logic [gks_pkg::DIST_BITS-1:0] rd_dist,
  output logic [gks_pkg::DIST_BITS-1:0] best_dist,
  output logic [gks_pkg::SRV_W-1:0]     best_idx
);
  import gks_pkg::*;

  gks_cand_t            cand_r;
  logic [DIST_BITS-1:0] best_dist_r, best_dist_nxt;
  logic [SRV_W-1:0]     best_idx_r, best_idx_nxt;

  // candidate tag lines up with the ram read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= issue;
    end
  end

  always_comb begin
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    if (cand_r.vld && (cand_r.first || (rd_dist < best_dist_r))) begin
      best_dist_nxt = rd_dist;
      best_idx_nxt  = cand_r.idx;
    end
  end

  always_ff @(posedge clk) begin
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
  end

  assign best_dist = best_dist_r;
  assign best_idx  = best_idx_r;

endmodule

/* src/greedy_k_server_policy_core.sv */
// ----------------------------------------------------------------------------
// greedy_k_server_policy_core
// greedy online k-server policy over a loaded distance table
// ----------------------------------------------------------------------------
// usage:
//   input beats (in_valid/in_ready) carry a request type: load writes one
//   distance entry, restart puts server i at point i and clears the total,
//   serve asks for a point. only serve beats give an output beat
//   (out_valid/out_ready) with the moved server, step cost and total.
//   cfg_we/cfg_wdata set the number of active servers while idle.
// sequence:
//   load and restart finish in S_IDLE as they are taken. a covered serve goes
//   to S_FINISH and then to the output register; otherwise S_SCAN reads one
//   distance entry per active server through the single ram read port, then
//   S_WAIT and S_FINISH follow. in_ready is low during a serve.
// reset:
//   rst_n clears the servers to their home points, the total to zero and
//   the server count to one. the distance table holds no reset value.
// stalls:
//   a finished result waits in the output register; new loads and restarts
//   are still taken, and a following serve holds at its final step until
//   the receiver takes the waiting beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "greedy_k_server_policy_core_macros.svh"

module greedy_k_server_policy_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gks_pkg::gks_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gks_pkg::gks_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [gks_pkg::NSRV_W-1:0] cfg_wdata
);
  import gks_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SRV_W-1:0]     cnt_r, cnt_nxt;
  logic [PT_W-1:0]      pa_r, pa_nxt;
  logic                 moved_r, moved_nxt;
  logic [NSRV_W-1:0]    cfg_r, cfg_nxt;
  logic [COST_W-1:0]    cost_r, cost_nxt;
  logic [PT_W-1:0]      pos_r [MAX_SERVERS];
  logic [PT_W-1:0]      pos_nxt [MAX_SERVERS];
  logic                 out_valid_r, out_valid_nxt;
  gks_out_t             out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 finish_go;
  logic [SRV_W-1:0]     last_idx;
  logic [MAX_SERVERS-1:0] cover_vec;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DIST_BITS-1:0] ram_rdata;
  gks_cand_t            issue;
  logic [DIST_BITS-1:0] best_dist;
  logic [SRV_W-1:0]     best_idx;
  logic [COST_W:0]      cost_sum;
  logic [COST_W-1:0]    cost_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign finish_go = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // active server count clamped to 1..MAX_SERVERS
  always_comb begin
    if (cfg_r == '0) begin
      last_idx = '0;
    end else if (cfg_r > NSRV_W'(MAX_SERVERS)) begin
      last_idx = SRV_W'(MAX_SERVERS - 1);
    end else begin
      last_idx = SRV_W'(cfg_r - NSRV_W'(1));
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_SERVERS; j++) begin
      cover_vec[j] = (SRV_W'(j) <= last_idx) && (pos_r[j] == in_data.point_a);
    end
  end

  assign ram_we    = in_fire && (in_data.req_type == REQ_LOAD);
  assign ram_raddr = {pa_r, pos_r[cnt_r]};
  assign issue.vld   = (state_r == S_SCAN);
  assign issue.first = (cnt_r == '0);
  assign issue.idx   = cnt_r;

  gks_dist_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_data.point_a, in_data.point_b}),
    .wdata (in_data.distance),
    .re    (issue.vld),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gks_min_unit u_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .rd_dist   (ram_rdata),
    .best_dist (best_dist),
    .best_idx  (best_idx)
  );

  assign cost_sum = {1'b0, cost_r} + (COST_W+1)'(best_dist);
  assign cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pa_nxt        = pa_r;
    moved_nxt     = moved_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    cost_nxt      = cost_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            REQ_SERVE: begin
              pa_nxt    = in_data.point_a;
              cnt_nxt   = '0;
              moved_nxt = ~|cover_vec;
              state_nxt = (|cover_vec) ? S_FINISH : S_SCAN;
            end
            REQ_RESTART: begin
              for (int i = 0; i < MAX_SERVERS; i++) begin
                pos_nxt[i] = PT_W'(i);
              end
              cost_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r == last_idx) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + SRV_W'(1);
        end
      end
      S_WAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (finish_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (moved_r) begin
            cost_nxt                  = cost_sat;
            pos_nxt[best_idx]         = pa_r;
            out_data_nxt.server_index = best_idx;
            out_data_nxt.moved        = 1'b1;
            out_data_nxt.step_cost    = best_dist;
            out_data_nxt.total_cost   = cost_sat;
          end else begin
            out_data_nxt.server_index = '0;
            out_data_nxt.moved        = 1'b0;
            out_data_nxt.step_cost    = '0;
            out_data_nxt.total_cost   = cost_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      moved_r     <= 1'b0;
      cfg_r       <= NSRV_W'(1);
      cost_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        pos_r[i] <= PT_W'(i);
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      moved_r     <= moved_nxt;
      cfg_r       <= cfg_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    out_data_r <= out_data_nxt;
  end

  `GKS_ASSERT_NXT(a_finish_emits, finish_go, out_valid_r && (state_r == S_IDLE), "serve did not produce a beat")
  `GKS_ASSERT_NXT(a_wait_to_finish, state_r == S_WAIT, state_r == S_FINISH, "scan did not settle in one cycle")
  `GKS_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, cnt_r <= last_idx, "scan ran past the active servers")
  `GKS_ASSERT_IMP(a_covered_zero, out_valid_r && !out_data_r.moved, (out_data_r.step_cost == '0) && (out_data_r.server_index == '0), "covered request carries a cost")

endmodule

/* tb/tb_greedy_k_server_policy_core.sv */
// ----------------------------------------------------------------------------
// tb_greedy_k_server_policy_core
// self-checking bench for the greedy k-server core: fills the distance table,
// runs directed and random request mixes under several server counts, bounces
// one server at the largest step cost, and checks every output beat against
// an in-bench greedy predictor with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_k_server_policy_core;
  import gks_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_GAP = 16;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 330;
  localparam int BOUNCE_SERVES = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  gks_in_t in_data;
  logic out_valid;
  logic out_ready;
  gks_out_t out_data;
  logic cfg_we;
  logic [NSRV_W-1:0] cfg_wdata;

  greedy_k_server_policy_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [PT_W-1:0]      srv_pos [MAX_SERVERS];
  logic [DIST_BITS-1:0] dist_tab [MAX_POINTS*MAX_POINTS];
  logic [COST_W-1:0]    cost_total;
  logic [NSRV_W-1:0]    nsrv_reg;

  gks_in_t  req_q[$];
  gks_out_t moves_due[$];

  bit in_took = 0;
  bit flat_out = 0;
  int unsigned cycles = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_moves = 0;
  int n_covered = 0;
  int n_cfg = 0;
  int n_bad = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic greedy_step(input gks_in_t b);
    int k;
    int best;
    logic [DIST_BITS-1:0] best_d;
    logic [DIST_BITS-1:0] d;
    logic [COST_W:0] sum;
    bit covered;
    gks_out_t r;
    case (b.req_type)
      REQ_LOAD: begin
        dist_tab[{b.point_a, b.point_b}] = b.distance;
      end
      REQ_RESTART: begin
        for (int i = 0; i < MAX_SERVERS; i++) srv_pos[i] = PT_W'(i % MAX_POINTS);
        cost_total = '0;
      end
      REQ_SERVE: begin
        k = (nsrv_reg == 0) ? 1 : (nsrv_reg > MAX_SERVERS) ? MAX_SERVERS : int'(nsrv_reg);
        covered = 0;
        for (int j = 0; j < k; j++) if (srv_pos[j] == b.point_a) covered = 1;
        r = '0;
        if (covered) begin
          r.total_cost = cost_total;
        end else begin
          best = 0;
          best_d = dist_tab[{b.point_a, srv_pos[0]}];
          for (int j = 1; j < k; j++) begin
            d = dist_tab[{b.point_a, srv_pos[j]}];
            if (d < best_d) begin
              best = j;
              best_d = d;
            end
          end
          sum = {1'b0, cost_total} + (COST_W+1)'(best_d);
          cost_total = sum[COST_W] ? '1 : sum[COST_W-1:0];
          srv_pos[best] = b.point_a;
          r.server_index = SRV_W'(best);
          r.moved = 1'b1;
          r.step_cost = best_d;
          r.total_cost = cost_total;
        end
        moves_due.insert(moves_due.size(), r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input longint unsigned e,
                             input longint unsigned a);
    if (e != a) begin
      n_bad++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, e, a);
    end
  endtask

  task automatic check_result(input gks_out_t got);
    gks_out_t want;
    if (moves_due.size() == 0) begin
      n_bad++;
      $display("%0t: unexpected beat, expected none, actual %p", $time, got);
    end else begin
      want = moves_due.pop_front();
      n_checked++;
      if (want.moved) n_moves++;
      else n_covered++;
      check_field("server_index", want.server_index, got.server_index);
      check_field("moved", want.moved, got.moved);
      check_field("step_cost", want.step_cost, got.step_cost);
      check_field("total_cost", want.total_cost, got.total_cost);
    end
  endtask

  // monitor: capture config, track accepted inputs, check output beats
  always @(posedge clk) begin
    in_took = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SERVERS; i++) srv_pos[i] = PT_W'(i % MAX_POINTS);
      cost_total = '0;
      nsrv_reg = NSRV_W'(1);
    end else begin
      if (cfg_we) nsrv_reg = cfg_wdata;
      if (out_valid && out_ready) check_result(out_data);
      if (in_took) begin
        n_beats++;
        greedy_step(in_data);
      end
    end
  end

  // driver: bursts of beats with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (gap_left > 0 && !flat_out) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (req_q.size() > 0) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: alternating ready and stall runs
  bit rx_on = 1;
  int rx_left = 0;
  always @(negedge clk) begin
    if (flat_out) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left <= 0) begin
        rx_on = !rx_on;
        if (rx_on) rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
        else rx_left = $urandom_range(1, 9);
      end
      rx_left--;
      out_ready <= rx_on;
    end
  end

  function automatic logic [DIST_BITS-1:0] pick_dist();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: pick_dist = DIST_BITS'($urandom_range(0, 4));
      5: pick_dist = '1;
      6: pick_dist = '0;
      default: pick_dist = DIST_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PT_W-1:0] pick_point();
    if ($urandom_range(0, 1) == 0) pick_point = PT_W'($urandom_range(0, MAX_SERVERS - 1));
    else pick_point = PT_W'($urandom);
  endfunction

  function automatic void send(input logic [1:0] t, input logic [PT_W-1:0] a,
                               input logic [PT_W-1:0] b, input logic [DIST_BITS-1:0] d);
    gks_in_t x;
    x.req_type = t;
    x.point_a = a;
    x.point_b = b;
    x.distance = d;
    req_q.insert(req_q.size(), x);
  endfunction

  task automatic drain();
    while (req_q.size() != 0 || in_valid || moves_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_servers(input logic [NSRV_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  logic [NSRV_W-1:0] phase_cfg [10] = '{1, 8, 0, 15, 2, 6, 9, 4, 7, 0};

  initial begin
    int n;
    int r;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // every entry written before any serve can read it
    for (int a = 0; a < MAX_POINTS; a++)
      for (int b = 0; b < MAX_POINTS; b++)
        send(REQ_LOAD, PT_W'(a), PT_W'(b), pick_dist());

    // directed: covered, max cost, ignored type, zero cost, ties, count limits
    send(REQ_SERVE, 4'd0, 4'hF, 16'hFFFF);
    send(REQ_LOAD, 4'd5, 4'd0, 16'hFFFF);
    send(REQ_SERVE, 4'd5, 4'd0, 16'h0000);
    send(REQ_UNUSED, 4'hF, 4'hF, 16'hFFFF);
    send(REQ_SERVE, 4'd5, 4'd0, 16'h0000);
    send(REQ_RESTART, 4'hF, 4'hF, 16'hFFFF);
    send(REQ_LOAD, 4'hF, 4'd0, 16'h0000);
    send(REQ_SERVE, 4'hF, 4'hF, 16'hFFFF);
    set_servers(4'd8);
    send(REQ_RESTART, 4'd0, 4'd0, 16'h0000);
    for (int c = 0; c < MAX_SERVERS; c++)
      send(REQ_LOAD, 4'd12, PT_W'(c), (c == 3 || c == 6) ? 16'd7 : 16'd9);
    send(REQ_SERVE, 4'd12, 4'd0, 16'h0000);
    send(REQ_SERVE, 4'd7, 4'd0, 16'h0000);
    set_servers(4'd0);
    send(REQ_RESTART, 4'd0, 4'd0, 16'h0000);
    send(REQ_SERVE, 4'd3, 4'd0, 16'h0000);
    set_servers(4'd15);
    send(REQ_SERVE, 4'd12, 4'd0, 16'h0000);

    // random mix over several server counts
    for (int p = 0; p < 10; p++) begin
      set_servers((p == 9) ? NSRV_W'($urandom) : phase_cfg[p]);
      n = 0;
      while (n < RANDOM_ITEMS / 10) begin
        r = $urandom_range(0, 99);
        if (r < 70) send(REQ_SERVE, pick_point(), PT_W'($urandom), DIST_BITS'($urandom));
        else if (r < 85) send(REQ_LOAD, PT_W'($urandom), PT_W'($urandom), pick_dist());
        else if (r < 94) send(REQ_RESTART, PT_W'($urandom), PT_W'($urandom),
                              DIST_BITS'($urandom));
        else send(REQ_UNUSED, PT_W'($urandom), PT_W'($urandom), DIST_BITS'($urandom));
        if (r < 94) n++;
      end
    end

    // bounce one server between two far points at the largest step cost
    set_servers(4'd1);
    flat_out = 1;
    send(REQ_RESTART, 4'd0, 4'd0, 16'h0000);
    send(REQ_LOAD, 4'd1, 4'd0, 16'hFFFF);
    send(REQ_LOAD, 4'd0, 4'd1, 16'hFFFF);
    for (int i = 0; i < BOUNCE_SERVES; i++)
      send(REQ_SERVE, (i % 2 == 0) ? 4'd1 : 4'd0, 4'd0, 16'h0000);
    send(REQ_RESTART, 4'd0, 4'd0, 16'h0000);
    send(REQ_SERVE, 4'd1, 4'd0, 16'h0000);
    drain();
    flat_out = 0;

    $display("run covered %0d input beats, %0d config writes, %0d cycles", n_beats,
             n_cfg, cycles);
    $display("checked %0d results: %0d moves, %0d covered, %0d mismatches", n_checked,
             n_moves, n_covered, n_bad);
    if (n_bad == 0 && moves_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
